### rtl/mbse_pkg.sv
// Shared types, constants and helper functions for the Mandelbrot smooth escape-time block.
// Holds the log2 ROM contents, which are built at elaboration from repeated squaring.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package mbse_pkg;

  // Fixed-point format of c and z, and size of the log2 table.
  localparam int FRAC_BITS      = 28;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
  localparam int Q_BITS         = 16;

  // Field widths.
  localparam int C_W    = 32;
  localparam int ITER_W = 10;
  localparam int SMO_W  = 18;
  localparam int PROD_W = 2 * C_W;
  localparam int Z_W    = PROD_W - FRAC_BITS;
  localparam int SQ_W   = 2 * Z_W - FRAC_BITS;
  localparam int MAG_W  = SQ_W + 1;
  localparam int POS_W  = $clog2(MAG_W);
  localparam int LM_W   = POS_W + Q_BITS;
  localparam int LL_W   = LM_W + 1;
  localparam int V_W    = ITER_W + Q_BITS + 2;

  // Escape radius squared, 4.0 in the z format.
  localparam logic [MAG_W-1:0] MAG_FOUR = MAG_W'(4) << FRAC_BITS;

  // 2 + log2(1/ln 2) in Q.16.
  localparam int SMOOTH_BIAS = 165725;

  // Input and result items.
  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } in_t;

  typedef struct packed {
    logic [SMO_W-1:0]  smooth_value;
    logic [ITER_W-1:0] iteration_count;
    logic              inside_set;
  } out_t;

  // A finished point handed from the iteration ring to the smoothing pipeline.
  typedef struct packed {
    logic [ITER_W-1:0] iter;
    logic [MAG_W-1:0]  mag;
    logic              in_set;
    logic [ITER_W-1:0] max_iter;
  } esc_t;

  typedef logic [Q_BITS-1:0] lg_rom_t [LOG_TABLE_SIZE];

  // Entry i is log2(1 + i/size) in Q.16, found by 16 squaring steps in Q1.30.
  function automatic lg_rom_t build_lg_rom();
    lg_rom_t           rom;
    logic [63:0]       y;
    logic [Q_BITS-1:0] r;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      y = (64'(1) << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int k = 0; k < Q_BITS; k++) begin
        y = (y * y) >> 30;
        r = {r[Q_BITS-2:0], 1'b0};
        if (y >= (64'(2) << 30)) begin
          y    = y >> 1;
          r[0] = 1'b1;
        end
      end
      rom[i] = r;
    end
    return rom;
  endfunction

  localparam lg_rom_t LG_ROM = build_lg_rom();

  // Position of the leading one; zero for a zero word.
  function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  // Table index: the bits just below the leading one.
  function automatic logic [LOG_TABLE_BITS-1:0] lg_index(input logic [MAG_W-1:0] v,
                                                          input logic [POS_W-1:0] p);
    logic [MAG_W-1:0] sh;
    sh = v >> (p - POS_W'(LOG_TABLE_BITS));
    return sh[LOG_TABLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/mbse_iter_ring.sv
// Iteration ring: three register stages that carry up to three points round and round,
// one complex iteration per trip, retiring finished points in arrival order.
// Depends on mbse_pkg.
`default_nettype none

module mbse_iter_ring (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [mbse_pkg::ITER_W-1:0] max_iter,
  input  wire logic                      in_valid,
  input  wire mbse_pkg::in_t             in_data,
  output logic                           in_stall,
  output logic                           esc_valid,
  input  wire logic                      esc_ready,
  output mbse_pkg::esc_t                 esc
);
  import mbse_pkg::*;

  typedef struct packed {
    logic                     done;
    logic [1:0]               tag;
    logic [ITER_W-1:0]        iter;
    logic signed [C_W-1:0]    cr;
    logic signed [C_W-1:0]    ci;
    logic signed [Z_W-1:0]    zr;
    logic signed [Z_W-1:0]    zi;
    logic signed [Z_W-1:0]    rr;
    logic signed [Z_W-1:0]    ii;
    logic signed [Z_W-1:0]    ri;
    logic [SQ_W-1:0]          sq_r;
    logic [SQ_W-1:0]          sq_i;
  } slot_t;

  localparam logic signed [PROD_W-1:0] TRUNC_ADJ = (PROD_W'(1) <<< FRAC_BITS) - PROD_W'(1);

  slot_t r0, r1, r2, s, r0_next, r1_next, r2_next;
  logic  v0, v1, v2, v1_next;
  logic [1:0] in_tag, out_tag;

  logic [MAG_W-1:0]        mag0, mag_s;
  logic                    done0, done_s, retire, enter;
  logic signed [C_W-1:0]   zr32, zi32;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ri_adj;
  logic signed [Z_W-1:0]   zr_c, zi_c;
  logic signed [2*Z_W-1:0] p_sr, p_si;

  // Escape test on the slot coming round, and in-order retirement.
  assign mag0   = MAG_W'(r0.sq_r) + MAG_W'(r0.sq_i);
  assign done0  = (mag0 > MAG_FOUR) || (r0.iter >= max_iter);
  assign retire = v0 && done0 && (r0.tag == out_tag) && esc_ready;
  assign enter  = in_valid && (!v0 || retire);
  assign in_stall = v0 && !retire;

  // Stage A: pick the new item or the circulating slot and form the three products.
  always_comb begin
    s = r0;
    if (enter) begin
      s     = '0;
      s.tag = in_tag;
      s.cr  = in_data.c_real;
      s.ci  = in_data.c_imag;
    end
    mag_s  = MAG_W'(s.sq_r) + MAG_W'(s.sq_i);
    done_s = (mag_s > MAG_FOUR) || (s.iter >= max_iter);
    zr32   = s.zr[C_W-1:0];
    zi32   = s.zi[C_W-1:0];
    p_rr   = zr32 * zr32;
    p_ii   = zi32 * zi32;
    p_ri   = zr32 * zi32;
    // Cross product truncates toward zero.
    p_ri_adj = p_ri + (p_ri[PROD_W-1] ? TRUNC_ADJ : '0);
    r1_next      = s;
    r1_next.done = done_s;
    r1_next.rr   = Z_W'(p_rr >>> FRAC_BITS);
    r1_next.ii   = Z_W'(p_ii >>> FRAC_BITS);
    r1_next.ri   = Z_W'(p_ri_adj >>> FRAC_BITS);
    v1_next      = enter || (v0 && !retire);
  end

  // Stage B: new z from the products; a finished point passes unchanged.
  always_comb begin
    r2_next = r1;
    if (!r1.done) begin
      r2_next.zr   = r1.rr - r1.ii + Z_W'(r1.cr);
      r2_next.zi   = (r1.ri <<< 1) + Z_W'(r1.ci);
      r2_next.iter = r1.iter + ITER_W'(1);
    end
  end

  // Stage C: squares of the new z for the next escape test.
  always_comb begin
    r0_next = r2;
    zr_c    = r2.zr;
    zi_c    = r2.zi;
    p_sr    = zr_c * zr_c;
    p_si    = zi_c * zi_c;
    if (!r2.done) begin
      r0_next.sq_r = SQ_W'(p_sr >>> FRAC_BITS);
      r0_next.sq_i = SQ_W'(p_si >>> FRAC_BITS);
    end
  end

  // Valid bits and order tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      in_tag  <= '0;
      out_tag <= '0;
    end else begin
      v1 <= v1_next;
      v2 <= v1;
      v0 <= v2;
      if (enter) begin
        in_tag <= in_tag + 2'd1;
      end
      if (retire) begin
        out_tag <= out_tag + 2'd1;
      end
    end
  end

  // Slot payload moves every cycle.
  always_ff @(posedge clk) begin
    r1 <= r1_next;
    r2 <= r2_next;
    r0 <= r0_next;
  end

  // Finished point toward the smoothing pipeline.
  always_comb begin
    esc_valid    = retire;
    esc.iter     = r0.iter;
    esc.mag      = mag0;
    esc.in_set   = (r0.iter == max_iter);
    esc.max_iter = max_iter;
  end

endmodule

`default_nettype wire

### rtl/mbse_smooth.sv
// Smoothing pipeline: log2 of |z|^2, log2 of that, bias, rounding and clamping.
// Three register stages plus the output register, all held by one stall.
// Depends on mbse_pkg.
`default_nettype none

module mbse_smooth (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           esc_valid,
  input  wire mbse_pkg::esc_t esc,
  output logic                esc_ready,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mbse_pkg::out_t      out_data
);
  import mbse_pkg::*;

  typedef struct packed {
    logic [ITER_W-1:0] iter;
    logic              in_set;
    logic [ITER_W-1:0] max_iter;
    logic [LM_W-1:0]   lm;
  } lm_stage_t;

  typedef struct packed {
    logic [ITER_W-1:0]     iter;
    logic                  in_set;
    logic [ITER_W-1:0]     max_iter;
    logic signed [LL_W-1:0] ll;
  } ll_stage_t;

  esc_t      p0;
  lm_stage_t p1, p1_next;
  ll_stage_t p2, p2_next;
  out_t      od_next;
  logic      p0v, p1v, p2v, adv;

  logic [POS_W-1:0]       e1, e2;
  logic [LM_W-1:0]        ll_u;
  logic signed [V_W-1:0]  v, rv;
  logic [SMO_W+1:0]       sm_w;
  logic [SMO_W-1:0]       cap;

  assign adv       = !out_valid || !out_stall;
  assign esc_ready = adv;

  // log2(|z|^2) in Q.16.
  always_comb begin
    e1               = msb_pos(p0.mag);
    p1_next.iter     = p0.iter;
    p1_next.in_set   = p0.in_set;
    p1_next.max_iter = p0.max_iter;
    p1_next.lm       = {e1, {Q_BITS{1'b0}}} + LM_W'(LG_ROM[lg_index(p0.mag, e1)])
                       - LM_W'(FRAC_BITS << Q_BITS);
  end

  // log2 of that, less 16 for the Q.16 scale.
  always_comb begin
    e2               = msb_pos(MAG_W'(p1.lm));
    ll_u             = {e2, {Q_BITS{1'b0}}} + LM_W'(LG_ROM[lg_index(MAG_W'(p1.lm), e2)]);
    p2_next.iter     = p1.iter;
    p2_next.in_set   = p1.in_set;
    p2_next.max_iter = p1.max_iter;
    p2_next.ll       = $signed({1'b0, ll_u}) - LL_W'(Q_BITS << Q_BITS);
  end

  // Bias, round half up to Q.8, clamp to the limit; points inside the set and non-positive values give zero.
  always_comb begin
    v    = $signed({2'b00, p2.iter, {Q_BITS{1'b0}}}) + V_W'(SMOOTH_BIAS) - V_W'(p2.ll);
    rv   = v + V_W'(128);
    sm_w = rv[V_W-1:8];
    cap  = {p2.max_iter, 8'b0};
    od_next.iteration_count = p2.iter;
    od_next.inside_set      = p2.in_set;
    if (p2.in_set || (v <= 0)) begin
      od_next.smooth_value = '0;
    end else if (sm_w > (SMO_W + 2)'(cap)) begin
      od_next.smooth_value = cap;
    end else begin
      od_next.smooth_value = sm_w[SMO_W-1:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      p0v       <= 1'b0;
      p1v       <= 1'b0;
      p2v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p0v       <= esc_valid;
      p1v       <= p0v;
      p2v       <= p1v;
      out_valid <= p2v;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      p0       <= esc;
      p1       <= p1_next;
      p2       <= p2_next;
      out_data <= od_next;
    end
  end

endmodule

`default_nettype wire

### rtl/mandelbrot_smooth_escape_time.sv
// Mandelbrot escape-time block with smooth coloring value.
// Each point makes at least one trip round the ring, one iteration per trip, then passes
// from retirement through the smoothing pipeline to the output register.
// Up to three points share the three-stage iteration ring; results leave in input order.
// Reset clears all valid bits and order tags and sets max_iterations to 100.
`default_nettype none

module mandelbrot_smooth_escape_time (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mbse_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mbse_pkg::out_t                   out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mbse_pkg::ITER_W-1:0] cfg_data
);
  import mbse_pkg::*;

  logic [ITER_W-1:0] max_iterations;
  logic              esc_valid, esc_ready;
  esc_t              esc;

  // Iteration limit register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= ITER_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  mbse_iter_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .max_iter  (max_iterations),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .esc_valid (esc_valid),
    .esc_ready (esc_ready),
    .esc       (esc)
  );

  mbse_smooth u_smooth (
    .clk       (clk),
    .rst       (rst),
    .esc_valid (esc_valid),
    .esc       (esc),
    .esc_ready (esc_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A point inside the set carries a zero smooth value.
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.inside_set |-> out_data.smooth_value == '0)
    else $error("inside point with nonzero smooth value");

  // An escaped point has done at least one iteration.
  a_escape_iter: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.inside_set |-> out_data.iteration_count != '0)
    else $error("escaped point with zero iterations");

  // A configuration write lands in the limit register.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> max_iterations == $past(cfg_data))
    else $error("iteration limit not updated");
`endif

endmodule

`default_nettype wire
